// File: hw/rtl/eclb_pkg.sv
// eclb_pkg: shared types and constants for the error code led blinker
// no dependencies; imported by eclb_regs, eclb_core and the top level

package eclb_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 4;
  localparam int unsigned CodeW = 8;
  localparam int unsigned TickW = 8;

  localparam logic [1:0] RegOnTicks    = 2'd0;
  localparam logic [1:0] RegOffTicks   = 2'd1;
  localparam logic [1:0] RegPauseTicks = 2'd2;

  localparam logic [TickW-1:0] OnTicksRst    = TickW'(18);
  localparam logic [TickW-1:0] OffTicksRst   = TickW'(18);
  localparam logic [TickW-1:0] PauseTicksRst = TickW'(80);

  localparam logic ModeTick    = 1'b0;
  localparam logic ModeSetCode = 1'b1;

  typedef struct packed {
    logic [TickW-1:0] on_ticks;
    logic [TickW-1:0] off_ticks;
    logic [TickW-1:0] pause_ticks;
  } cfg_t;

endpackage

// File: hw/rtl/eclb_regs.sv
// eclb_regs: apb-style register file for the blink timing settings
// depends on eclb_pkg

module eclb_regs
  import eclb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_ticks    <= OnTicksRst;
      cfg.off_ticks   <= OffTicksRst;
      cfg.pause_ticks <= PauseTicksRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegOnTicks:    cfg.on_ticks    <= pwdata[TickW-1:0];
        RegOffTicks:   cfg.off_ticks   <= pwdata[TickW-1:0];
        RegPauseTicks: cfg.pause_ticks <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegOnTicks:    prdata = DataW'(cfg.on_ticks);
      RegOffTicks:   prdata = DataW'(cfg.off_ticks);
      RegPauseTicks: prdata = DataW'(cfg.pause_ticks);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/eclb_core.sv
// eclb_core: blink sequencer and result register
// depends on eclb_pkg; timing settings come from eclb_regs

module eclb_core
  import eclb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [CodeW-1:0] new_code,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             led_on,
  output logic [CodeW-1:0] current_error
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ON    = 2'd1,
    PH_OFF   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_t;

  phase_t           phase, phase_next;
  logic [TickW-1:0] ticks_left, ticks_left_next;
  logic [7:0]       blinks_done, blinks_done_next;
  logic [CodeW-1:0] shown_code, shown_code_next;
  logic             led_level, led_level_next;
  logic             in_xfer;

  // results live in the state registers, so hold the input while one is stalled
  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  always_comb begin
    phase_next       = phase;
    ticks_left_next  = ticks_left;
    blinks_done_next = blinks_done;
    shown_code_next  = shown_code;
    led_level_next   = led_level;
    if (mode == ModeSetCode) begin
      if (new_code == '0) begin
        phase_next     = PH_IDLE;
        led_level_next = 1'b0;
      end else if (new_code != shown_code) begin
        phase_next = PH_OFF;
      end
      shown_code_next = new_code;
    end else if (ticks_left != '0) begin
      ticks_left_next = ticks_left - 1'b1;
    end else begin
      unique case (phase)
        PH_ON: begin
          if (blinks_done != 8'hff) begin
            blinks_done_next = blinks_done + 1'b1;
          end
          phase_next      = PH_OFF;
          ticks_left_next = cfg.off_ticks;
          led_level_next  = 1'b0;
        end
        PH_OFF: begin
          if (blinks_done >= shown_code) begin
            phase_next      = PH_PAUSE;
            ticks_left_next = cfg.pause_ticks;
          end else begin
            phase_next      = PH_ON;
            ticks_left_next = cfg.on_ticks;
            led_level_next  = 1'b1;
          end
        end
        PH_PAUSE: begin
          blinks_done_next = '0;
          phase_next       = PH_ON;
          ticks_left_next  = cfg.on_ticks;
          led_level_next   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      ticks_left  <= '0;
      blinks_done <= '0;
      shown_code  <= '0;
      led_level   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase       <= phase_next;
        ticks_left  <= ticks_left_next;
        blinks_done <= blinks_done_next;
        shown_code  <= shown_code_next;
        led_level   <= led_level_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign led_on        = led_level;
  assign current_error = shown_code;

  a_idle_dark : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> !led_level)
    else $error("led lit while idle");

  a_idle_code : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) == (shown_code == '0))
    else $error("idle phase and zero code disagree");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(led_level) && $stable(shown_code)))
    else $error("stalled result changed");

  a_countdown : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && mode == ModeTick && ticks_left != '0) |=>
      (ticks_left == $past(ticks_left) - 1'b1) && (phase == $past(phase)))
    else $error("countdown tick misbehaved");

endmodule

// File: hw/rtl/error_code_led_blinker_top.sv
// error_code_led_blinker_top: top level of the error code led blinker
// depends on eclb_pkg, eclb_regs and eclb_core

// Takes one item (a timer tick or a new error code) per clock cycle and gives
// exactly one result per item, in the cycle after its transfer, from the
// sequencer's state registers. While a result is stalled the input is stalled
// too, so the sustained rate is one item per cycle when the output is not
// held. Timing registers: on_ticks at 0x0, off_ticks at 0x4, pause_ticks at
// 0x8 (reset 18, 18, 80); change them only while the block is idle.

module error_code_led_blinker_top
  import eclb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [CodeW-1:0] new_code,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             led_on,
  output logic [CodeW-1:0] current_error
);

  cfg_t cfg;

  eclb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eclb_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .new_code      (new_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .led_on        (led_on),
    .current_error (current_error)
  );

endmodule
